@@ hdl/bfb_pkg.sv @@
// Shared types and constants for the bloom filter builder.
package bfb_pkg;

  // Fixed field and hash widths
  localparam int HASH_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 16;
  localparam int WORD_W     = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Cell index is the hash above its three bit-select bits
  localparam int DIV_BITS   = HASH_W - 3;

  // Parameter defaults
  localparam int BLOOM_BYTES_DEF = 512;
  localparam int HASH_COUNT_DEF  = 8;

  // Register reset values
  localparam logic [CNT_W-1:0] ITEM_LENGTH_RST      = 16'd100;
  localparam logic [CNT_W-1:0] ITEMS_PER_FILTER_RST = 16'd3072;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ITEM_LENGTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ITEMS_PER_FILTER = 2'd1;

  // Operations of the shared hash lane unit
  typedef enum logic [1:0] {
    LANE_NOP,
    LANE_STEP,
    LANE_FIN
  } lane_op_t;

  typedef struct packed {
    lane_op_t          op;
    logic [BYTE_W-1:0] data;
  } lane_cmd_t;

endpackage

@@ hdl/bfb_lane_file.sv @@
// Hash lane registers with one shared mix/finalize unit, one lane per cycle.
module bfb_lane_file #(
  parameter int HASH_COUNT = bfb_pkg::HASH_COUNT_DEF,
  parameter int LANE_IW    = 3
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bfb_pkg::lane_cmd_t        cmd,
  input  logic [LANE_IW-1:0]        lane_sel,
  output logic [bfb_pkg::HASH_W-1:0] fin_hash
);
  import bfb_pkg::*;

  logic [HASH_W-1:0] lanes_r [HASH_COUNT];
  logic [HASH_W-1:0] fin_r;
  logic [HASH_W-1:0] cur;
  logic [HASH_W-1:0] step_val;
  logic [HASH_W-1:0] fin_val;

  // One byte of one-at-a-time mixing
  function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] c;
    a = h + HASH_W'(b);
    c = a + (a << 10);
    return c ^ (c >> 6);
  endfunction

  // Final avalanche of a lane
  function automatic logic [HASH_W-1:0] finalize(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] c;
    a = h + (h << 3);
    c = a ^ (a >> 11);
    return c + (c << 15);
  endfunction

  // Select the lane under work and run it through the shared unit
  always_comb begin
    cur      = lanes_r[lane_sel];
    step_val = mix_byte(cur, cmd.data);
    fin_val  = finalize(cur);
  end

  // Update the selected lane; finalizing returns it to its seed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < HASH_COUNT; k++) begin
        lanes_r[k] <= HASH_W'(k);
      end
    end else begin
      unique case (cmd.op)
        LANE_STEP: lanes_r[lane_sel] <= step_val;
        LANE_FIN:  lanes_r[lane_sel] <= HASH_W'(lane_sel);
        default: ;
      endcase
    end
  end

  // Hold the finalized hash for the cell index and bit update
  always_ff @(posedge clk) begin
    if (cmd.op == LANE_FIN) begin
      fin_r <= fin_val;
    end
  end

  assign fin_hash = fin_r;

endmodule

@@ hdl/bfb_mod_unit.sv @@
// Remainder unit: cell index modulo a constant filter size by reciprocal multiplication.
module bfb_mod_unit #(
  parameter int MODULUS = bfb_pkg::BLOOM_BYTES_DEF,
  parameter int REM_W   = $clog2(bfb_pkg::BLOOM_BYTES_DEF)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bfb_pkg::DIV_BITS-1:0] dividend,
  output logic                         done,
  output logic [REM_W-1:0]             rem
);
  import bfb_pkg::*;

  // Reciprocal scaled by 2^32; the estimated quotient is exact or one short
  localparam int RECIP_SH = HASH_W;
  localparam int RECIP_W  = DIV_BITS + 1;
  localparam int PROD_W   = DIV_BITS + RECIP_W;
  localparam int QUO_W    = DIV_BITS - 3;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / 64'(MODULUS));
  localparam logic [REM_W:0]     MOD_R = (REM_W + 1)'(MODULUS);

  logic [DIV_BITS-1:0] dvd_r;
  logic [QUO_W-1:0]    quo_r;
  logic [REM_W:0]      part_r;
  logic [REM_W-1:0]    rem_r;
  logic [2:0]          stage_r;
  logic                done_r;
  logic [PROD_W-1:0]   prod;
  logic [REM_W:0]      back_prod;
  logic [REM_W:0]      part_nxt;

  // Estimate the quotient, then take the partial remainder in its low bits only
  always_comb begin
    prod      = PROD_W'(dvd_r) * PROD_W'(RECIP);
    back_prod = (REM_W + 1)'(quo_r) * MOD_R;
    part_nxt  = dvd_r[REM_W:0] - back_prod;
  end

  // Advance the three steps; done follows the final correction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= {stage_r[1:0], start};
      done_r  <= stage_r[2];
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
    end
    if (stage_r[0]) begin
      quo_r <= prod[RECIP_SH +: QUO_W];
    end
    if (stage_r[1]) begin
      part_r <= part_nxt;
    end
    // Subtract the modulus once more when the estimate was one short
    if (stage_r[2]) begin
      if (part_r >= MOD_R) begin
        rem_r <= REM_W'(part_r - MOD_R);
      end else begin
        rem_r <= part_r[REM_W-1:0];
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

@@ hdl/bfb_filter_mem.sv @@
// Filter store: 64-bit words, one write and one registered read per cycle.
module bfb_filter_mem #(
  parameter int WORD_COUNT = 64,
  parameter int ADDR_W     = 6
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          waddr,
  input  logic [bfb_pkg::WORD_W-1:0] wdata,
  input  logic                       re,
  input  logic [ADDR_W-1:0]          raddr,
  output logic [bfb_pkg::WORD_W-1:0] rdata
);
  import bfb_pkg::*;

  logic [WORD_W-1:0] mem [WORD_COUNT];
  logic [WORD_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/bloom_filter_builder_unit.sv @@
// Bloom filter builder: top level with the sequencer, counters and output register.
//
// Input channel in_valid/in_ready/in_data_byte takes one byte of the item stream
// per transaction. Each byte is mixed into HASH_COUNT hash lanes by one shared
// unit, one lane per cycle; in_ready returns only once every lane is mixed.
// The byte that completes an item (item_length bytes) adds, per lane, a finalize
// state, a start state, a wait on the reciprocal remainder unit and a
// read-modify-write (read state, then set state) of the filter store.
// After items_per_filter items the filter is dumped on out_valid/out_ready as
// (BLOOM_BYTES+7)/8 words of 64 bits, out_last_word marking the final one,
// and each word is cleared as it is read. Each word passes a read state and a
// load state; a stalled receiver holds the dump in place. After the last word
// is loaded into the output register, input is taken again while it waits.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) go straight into their registers.
// Reset (rst_n low, synchronous) restores the registers and hash seeds and then
// runs a clearing pass over all (BLOOM_BYTES+7)/8 words of the filter store, with
// in_ready low throughout.
module bloom_filter_builder_unit #(
  parameter int BLOOM_BYTES = bfb_pkg::BLOOM_BYTES_DEF,
  parameter int HASH_COUNT  = bfb_pkg::HASH_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bfb_pkg::BYTE_W-1:0]     in_data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bfb_pkg::WORD_W-1:0]     out_filter_word,
  output logic                           out_last_word,
  input  logic                           cfg_we,
  input  logic [bfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bfb_pkg::*;

  localparam int WORD_COUNT = (BLOOM_BYTES + 7) / 8;
  localparam int WAW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int LANE_IW    = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;
  localparam int REM_W      = $clog2(BLOOM_BYTES);
  localparam logic [WAW-1:0]     LAST_WORD = WAW'(WORD_COUNT - 1);
  localparam logic [LANE_IW-1:0] LAST_LANE = LANE_IW'(HASH_COUNT - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_FIN,
    ST_MODGO,
    ST_MOD,
    ST_RD,
    ST_SET,
    ST_DUMP_RD,
    ST_DUMP_LD
  } state_t;

  state_t               state_r;
  logic [LANE_IW-1:0]   lane_r;
  logic [WAW-1:0]       word_r;
  logic [CNT_W-1:0]     byte_cnt_r;
  logic [CNT_W-1:0]     item_cnt_r;
  logic                 item_end_r;
  logic [BYTE_W-1:0]    data_r;
  logic                 out_valid_r;
  logic [WORD_W-1:0]    out_word_r;
  logic                 out_last_r;
  logic [CNT_W-1:0]     item_length_r;
  logic [CNT_W-1:0]     items_per_filter_r;

  lane_cmd_t            lane_cmd;
  logic [HASH_W-1:0]    fin_hash;
  logic                 mod_start;
  logic                 mod_done;
  logic [REM_W-1:0]     cell_rem;
  logic [REM_W-1:0]     cell_shr;
  logic [WAW-1:0]       cell_word;
  logic [5:0]           bit_pos;
  logic [CNT_W-1:0]     byte_cnt_inc;
  logic [CNT_W-1:0]     item_cnt_inc;
  logic                 out_load;
  logic                 mem_we;
  logic [WAW-1:0]       mem_waddr;
  logic [WORD_W-1:0]    mem_wdata;
  logic                 mem_re;
  logic [WAW-1:0]       mem_raddr;
  logic [WORD_W-1:0]    mem_rdata;

  // Cell address and bit within the 64-bit word
  assign cell_shr     = cell_rem >> 3;
  assign cell_word    = cell_shr[WAW-1:0];
  assign bit_pos      = {cell_rem[2:0], fin_hash[2:0]};
  assign byte_cnt_inc = byte_cnt_r + 1'b1;
  assign item_cnt_inc = item_cnt_r + 1'b1;

  // Output register takes the next dump word when it is free
  assign out_load = (state_r == ST_DUMP_LD) && (!out_valid_r || out_ready);

  // Decode lane unit, remainder unit and memory controls from the state
  always_comb begin
    lane_cmd.op   = LANE_NOP;
    lane_cmd.data = data_r;
    mod_start     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = word_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = word_r;
    unique case (state_r)
      ST_CLEAR:   mem_we = 1'b1;
      ST_HASH:    lane_cmd.op = LANE_STEP;
      ST_FIN:     lane_cmd.op = LANE_FIN;
      ST_MODGO:   mod_start = 1'b1;
      ST_RD: begin
        mem_re    = 1'b1;
        mem_raddr = cell_word;
      end
      ST_SET: begin
        mem_we    = 1'b1;
        mem_waddr = cell_word;
        mem_wdata = mem_rdata | (WORD_W'(1) << bit_pos);
      end
      ST_DUMP_RD: begin
        mem_re = 1'b1;
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      lane_r      <= '0;
      word_r      <= '0;
      byte_cnt_r  <= '0;
      item_cnt_r  <= '0;
      item_end_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the output word once the receiver takes it and nothing replaces it
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          if (word_r == LAST_WORD) begin
            word_r  <= '0;
            state_r <= ST_IDLE;
          end else begin
            word_r <= word_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            data_r     <= in_data_byte;
            lane_r     <= '0;
            byte_cnt_r <= byte_cnt_inc;
            item_end_r <= (byte_cnt_inc == item_length_r);
            state_r    <= ST_HASH;
          end
        end
        ST_HASH: begin
          if (lane_r == LAST_LANE) begin
            lane_r <= '0;
            if (item_end_r) begin
              byte_cnt_r <= '0;
              state_r    <= ST_FIN;
            end else begin
              state_r <= ST_IDLE;
            end
          end else begin
            lane_r <= lane_r + 1'b1;
          end
        end
        ST_FIN:   state_r <= ST_MODGO;
        ST_MODGO: state_r <= ST_MOD;
        ST_MOD: begin
          if (mod_done) begin
            state_r <= ST_RD;
          end
        end
        ST_RD: state_r <= ST_SET;
        ST_SET: begin
          if (lane_r == LAST_LANE) begin
            lane_r <= '0;
            if (item_cnt_inc == items_per_filter_r) begin
              item_cnt_r <= '0;
              word_r     <= '0;
              state_r    <= ST_DUMP_RD;
            end else begin
              item_cnt_r <= item_cnt_inc;
              state_r    <= ST_IDLE;
            end
          end else begin
            lane_r  <= lane_r + 1'b1;
            state_r <= ST_FIN;
          end
        end
        ST_DUMP_RD: state_r <= ST_DUMP_LD;
        ST_DUMP_LD: begin
          // Load the next word once the output register is free
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_word_r  <= mem_rdata;
            out_last_r  <= (word_r == LAST_WORD);
            if (word_r == LAST_WORD) begin
              word_r  <= '0;
              state_r <= ST_IDLE;
            end else begin
              word_r  <= word_r + 1'b1;
              state_r <= ST_DUMP_RD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_length_r      <= ITEM_LENGTH_RST;
      items_per_filter_r <= ITEMS_PER_FILTER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ITEM_LENGTH:      item_length_r      <= cfg_wdata;
        REG_ITEMS_PER_FILTER: items_per_filter_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_filter_word = out_word_r;
  assign out_last_word   = out_last_r;

  bfb_lane_file #(
    .HASH_COUNT (HASH_COUNT),
    .LANE_IW    (LANE_IW)
  ) u_lanes (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (lane_cmd),
    .lane_sel (lane_r),
    .fin_hash (fin_hash)
  );

  bfb_mod_unit #(
    .MODULUS (BLOOM_BYTES),
    .REM_W   (REM_W)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (fin_hash[HASH_W-1:3]),
    .done     (mod_done),
    .rem      (cell_rem)
  );

  bfb_filter_mem #(
    .WORD_COUNT (WORD_COUNT),
    .ADDR_W     (WAW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ hdl/bfb_checker.sv @@
// Port-level checks for the bloom filter builder, bound to the top level.
module bfb_port_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [bfb_pkg::WORD_W-1:0] out_filter_word,
  input logic                       out_last_word
);
  import bfb_pkg::*;

  // Hold a stalled output transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filter_word)
                                && $stable(out_last_word))
    else $error("stalled output transaction changed");

  // Reset starts the clearing pass with input closed
  assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input open right after reset");

  // An accepted byte keeps the block busy while lanes are mixed
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken during lane mixing");

  // Input stays closed while a word before the last one of a dump is offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_word |-> !in_ready)
    else $error("input open in the middle of a dump");

endmodule

bind bloom_filter_builder_unit bfb_port_checker u_bfb_port_checker (.*);

@@ sim/bfb_checker.sv @@
// Checker for the bloom filter builder: predicts every filter dump and compares each word.
`timescale 1ns / 100ps

module bfb_checker #(
  parameter int BLOOM_BYTES = bfb_pkg::BLOOM_BYTES_DEF,
  parameter int HASH_COUNT  = bfb_pkg::HASH_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [bfb_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [bfb_pkg::WORD_W-1:0]     out_filter_word,
  input  logic                           out_last_word,
  input  logic                           cfg_we,
  input  logic [bfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             err_count,
  output int                             pending,
  output int                             words_checked
);
  import bfb_pkg::*;

  localparam int WORDS = (BLOOM_BYTES + 7) / 8;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } filter_beat_t;

  // Shadow state of the block
  logic [HASH_W-1:0] lane_hash [HASH_COUNT];
  logic [CNT_W-1:0]  item_len;
  logic [CNT_W-1:0]  items_per_dump;
  logic [CNT_W-1:0]  byte_pos;
  logic [CNT_W-1:0]  item_pos;
  logic [BYTE_W-1:0] filter_mem [BLOOM_BYTES];
  filter_beat_t      dump_words_q [$];
  int                errs = 0;
  int                checked = 0;

  // One-at-a-time mixing of one byte into a lane
  function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] acc;
    acc = h + HASH_W'(b);
    acc = acc + (acc << 10);
    acc = acc ^ (acc >> 6);
    return acc;
  endfunction

  // Final avalanche of a lane at the end of an item
  function automatic logic [HASH_W-1:0] finish_hash(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] acc;
    acc = h + (h << 3);
    acc = acc ^ (acc >> 11);
    acc = acc + (acc << 15);
    return acc;
  endfunction

  task automatic reseed_lanes();
    for (int k = 0; k < HASH_COUNT; k++) lane_hash[k] = HASH_W'(k);
  endtask

  // Queue the whole filter as 64-bit words, then clear it
  task automatic load_dump();
    filter_beat_t beat;
    int addr;
    for (int w = 0; w < WORDS; w++) begin
      beat.word = '0;
      for (int i = 0; i < 8; i++) begin
        addr = w * 8 + i;
        if (addr < BLOOM_BYTES) beat.word[8*i +: 8] = filter_mem[addr];
      end
      beat.last = (w == WORDS - 1);
      dump_words_q.push_back(beat);
    end
    for (int a = 0; a < BLOOM_BYTES; a++) filter_mem[a] = '0;
  endtask

  // Advance the predicted state by one accepted byte
  task automatic absorb_byte(input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] h;
    int slot;
    for (int k = 0; k < HASH_COUNT; k++) lane_hash[k] = mix_byte(lane_hash[k], b);
    byte_pos = byte_pos + 1'b1;
    if (byte_pos == item_len) begin
      for (int k = 0; k < HASH_COUNT; k++) begin
        h = finish_hash(lane_hash[k]);
        slot = int'((h >> 3) % BLOOM_BYTES);
        filter_mem[slot][h[2:0]] = 1'b1;
      end
      reseed_lanes();
      byte_pos = '0;
      item_pos = item_pos + 1'b1;
      if (item_pos == items_per_dump) begin
        item_pos = '0;
        load_dump();
      end
    end
  endtask

  // Watch all three ports at each edge
  always @(posedge clk) begin : watch
    filter_beat_t want;
    if (!rst_n) begin
      item_len       = ITEM_LENGTH_RST;
      items_per_dump = ITEMS_PER_FILTER_RST;
      byte_pos       = '0;
      item_pos       = '0;
      reseed_lanes();
      for (int a = 0; a < BLOOM_BYTES; a++) filter_mem[a] = '0;
      dump_words_q.delete();
    end else begin
      // Compare an output transaction with the oldest predicted word
      if (out_valid && out_ready) begin
        if (dump_words_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected filter word: expected none, actual %h last %b",
                   $time, out_filter_word, out_last_word);
        end else begin
          want = dump_words_q.pop_front();
          checked++;
          if (out_filter_word !== want.word) begin
            errs++;
            $display("%0t: filter_word mismatch: expected %h, actual %h",
                     $time, want.word, out_filter_word);
          end
          if (out_last_word !== want.last) begin
            errs++;
            $display("%0t: last_word mismatch: expected %b, actual %b",
                     $time, want.last, out_last_word);
          end
        end
      end
      // Track register writes; other indexes are dropped
      if (cfg_we) begin
        if (cfg_index == REG_ITEM_LENGTH) item_len = cfg_wdata;
        else if (cfg_index == REG_ITEMS_PER_FILTER) items_per_dump = cfg_wdata;
      end
      if (in_valid && in_ready) absorb_byte(in_data_byte);
    end
    err_count     <= errs;
    pending       <= dump_words_q.size();
    words_checked <= checked;
  end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for the bloom filter builder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import bfb_pkg::*;

  localparam int CLK_HIGH      = 4;
  localparam int CLK_LOW       = 4;
  localparam int RESET_CYCLES  = 3;
  localparam int SETTLE_CYCLES = 400;
  localparam int DRAIN_CYCLES  = 300;
  localparam int HOLD_CYCLES   = 3000;
  localparam int STALL_LIMIT   = 20000;
  localparam int PHASE_BYTES   = 100;

  // Indexes past the register file, expected to be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_data_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [WORD_W-1:0]     out_filter_word;
  logic                  out_last_word;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int hold_req      = 0;
  int bytes_sent    = 0;
  int cfg_writes    = 0;
  int idle_run      = 0;
  int err_count;
  int pending;
  int words_checked;

  always begin
    #(CLK_LOW) clk = 1'b1;
    #(CLK_HIGH) clk = 1'b0;
  end

  bloom_filter_builder_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_filter_word (out_filter_word),
    .out_last_word   (out_last_word),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  bfb_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_filter_word (out_filter_word),
    .out_last_word   (out_last_word),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .err_count       (err_count),
    .pending         (pending),
    .words_checked   (words_checked)
  );

  // Stop the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_run);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    int hold_done;
    hold_done = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        out_ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        while (hold_left > 0) begin
          @(posedge clk);
          hold_left--;
        end
        hold_done = hold_req;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  // Offer one byte, idling first at the current rate, and hold it until taken
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0:       return 8'h00;
        1:       return 8'hFF;
        2:       return 8'h80;
        default: return 8'h7F;
      endcase
    end
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) send_byte(pick_byte());
  endtask

  // Drop valid, wait for every predicted word, then let the block settle
  task automatic wait_idle(input int gap);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (gap) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [BYTE_W-1:0] corner_bytes [8];
    int il;
    int ipf;
    int reps;
    int sent;
    corner_bytes[0] = 8'h00;
    corner_bytes[1] = 8'hFF;
    corner_bytes[2] = 8'h80;
    corner_bytes[3] = 8'h01;
    corner_bytes[4] = 8'h55;
    corner_bytes[5] = 8'hAA;
    corner_bytes[6] = 8'h7F;
    corner_bytes[7] = 8'hFE;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_wdata    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle(SETTLE_CYCLES);

    // One-byte items, one item per dump: each byte dumps the filter
    write_reg(REG_ITEM_LENGTH, 16'd1);
    write_reg(REG_ITEMS_PER_FILTER, 16'd1);
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_idle(SETTLE_CYCLES);

    // Two four-byte items of corner bytes; writes to spare indexes must not land
    write_reg(REG_ITEM_LENGTH, 16'd4);
    write_reg(REG_ITEMS_PER_FILTER, 16'd2);
    write_reg(REG_SPARE_2, 16'h0001);
    write_reg(REG_SPARE_3, 16'h0003);
    for (int n = 0; n < 8; n++) send_byte(corner_bytes[n]);
    wait_idle(SETTLE_CYCLES);

    // Zero items per filter: no dump, then raise it above the count
    write_reg(REG_ITEM_LENGTH, 16'd1);
    write_reg(REG_ITEMS_PER_FILTER, 16'd0);
    send_random(3);
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_ITEMS_PER_FILTER, 16'd5);
    send_random(2);
    wait_idle(SETTLE_CYCLES);

    // Item length lowered mid-item but still ahead of the byte count
    write_reg(REG_ITEM_LENGTH, 16'd10);
    write_reg(REG_ITEMS_PER_FILTER, 16'd1);
    send_random(4);
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_ITEM_LENGTH, 16'd6);
    send_random(2);
    wait_idle(SETTLE_CYCLES);

    // Random phases over the idling mixes; every group ends on a dump
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct   = 76;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct   = 0;
          out_stall_pct = 76;
        end
        default: begin
          in_idle_pct   = 14;
          out_stall_pct = 14;
        end
      endcase
      sent = 0;
      // Long receiver hold-off while bytes keep coming, so the input backs up
      if (phase == 0) hold_req++;
      while (sent < PHASE_BYTES) begin
        if (phase == 0 && sent == 0) begin
          il   = 1;
          ipf  = 1;
          reps = 3;
        end else begin
          il   = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 4);
          ipf  = $urandom_range(1, 4);
          reps = (il > 4) ? 1 : $urandom_range(1, 2);
        end
        write_reg(REG_ITEM_LENGTH, CFG_DATA_W'(il));
        write_reg(REG_ITEMS_PER_FILTER, CFG_DATA_W'(ipf));
        send_random(il * ipf * reps);
        wait_idle(SETTLE_CYCLES);
        sent += il * ipf * reps;
      end
    end

    // Largest settings, then item length zero, which the byte count does not reach here
    in_idle_pct   = 0;
    out_stall_pct = 0;
    write_reg(REG_ITEM_LENGTH, 16'hFFFF);
    write_reg(REG_ITEMS_PER_FILTER, 16'hFFFF);
    send_random(5);
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_ITEM_LENGTH, 16'h0000);
    send_random(3);
    wait_idle(DRAIN_CYCLES);

    $display("Sent %0d bytes with %0d register writes, zero and full-scale settings included",
             bytes_sent, cfg_writes);
    $display("Compared %0d filter words across four idling mixes and one long receiver hold-off",
             words_checked);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ bloom_filter_builder_unit.f @@
hdl/bfb_pkg.sv
hdl/bfb_lane_file.sv
hdl/bfb_mod_unit.sv
hdl/bfb_filter_mem.sv
hdl/bloom_filter_builder_unit.sv
hdl/bfb_checker.sv
sim/bfb_checker.sv
sim/tb_top.sv
